// ----- design/crlfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlfp_pkg
// shared constants and types of the crlf framed pose record parser
// ----------------------------------------------------------------------------
package crlfp_pkg;

    localparam int unsigned PAYLOAD_BYTES = 24;
    localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int unsigned WORD_BYTES    = 4;
    localparam int unsigned NUM_WORDS     = PAYLOAD_BYTES / WORD_BYTES;
    localparam int unsigned WORD_W        = 8 * WORD_BYTES;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam int unsigned OUT_DATA_W = 8 + NUM_WORDS * WORD_W;
    localparam int unsigned OUT_USER_W = 2;

    typedef struct packed {
        logic store_en;
        logic echo_valid;
        logic frame_done;
    } t_ctrl;

endpackage

// ----- design/crlf_framed_pose_record_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_framed_pose_record_parser_core
// byte stream parser for cr-lf framed pose records with byte echo
// ----------------------------------------------------------------------------
// Input channel (s_axis): one received serial byte per item, tdata = rx_byte,
// tuser = overrun flag. An overrun item is not echoed and restarts the header
// hunt. Output channel (m_axis): exactly one item per input item, in order.
// tdata carries the echoed byte and the six payload words, tuser carries
// echo_valid and frame_done. A frame completes on the trailer CR byte; that
// item carries the 24 payload bytes as little-endian 32-bit words.
// The payload lives in a row of 24 byte cells that shift one place per
// payload byte, so cell k holds payload byte k after the 24th byte.
// The result is registered in the output register, or in the skid register
// while the output stalls. Throughput: one item per cycle while the skid
// register is empty, set by the framing state machine and shift row.
// Stall: a one-item skid register sits behind the output register; when
// both are full, o_s_axis_tready drops until the receiver takes an item.
// Reset (i_rst_n low, synchronous) returns the parser to header hunt and
// empties the output stage; payload cells are not cleared.
// ----------------------------------------------------------------------------
module crlf_framed_pose_record_parser_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // rx_byte
    input  logic [0:0]                          i_s_axis_tuser,  // overrun
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // echo_byte, heading_word, roll_word, pitch_word, pos_x_word,
    // pos_y_word, yaw_rate_word
    output logic [crlfp_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // echo_valid, frame_done
    output logic [crlfp_pkg::OUT_USER_W-1:0]    o_m_axis_tuser
);

    localparam int unsigned NB = crlfp_pkg::PAYLOAD_BYTES;

    logic                               in_acc;
    logic                               out_take;
    crlfp_pkg::t_ctrl                   ctrl;
    logic [7:0]                         cell_byte [NB+1];
    logic [crlfp_pkg::OUT_DATA_W-1:0]   res_data;
    logic [crlfp_pkg::OUT_USER_W-1:0]   res_user;

    logic                               r_out_valid;
    logic [crlfp_pkg::OUT_DATA_W-1:0]   r_out_data;
    logic [crlfp_pkg::OUT_USER_W-1:0]   r_out_user;
    logic                               r_skid_valid;
    logic [crlfp_pkg::OUT_DATA_W-1:0]   r_skid_data;
    logic [crlfp_pkg::OUT_USER_W-1:0]   r_skid_user;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_acc          = i_s_axis_tvalid && !r_skid_valid;
    assign out_take        = r_out_valid && i_m_axis_tready;

    crlfp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_acc),
        .i_byte    (i_s_axis_tdata),
        .i_overrun (i_s_axis_tuser[0]),
        .o_ctrl    (ctrl)
    );

    // new byte enters at the top of the row and moves down
    assign cell_byte[NB] = i_s_axis_tdata;

    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_cell
            crlfp_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(ctrl.store_en),
                .i_byte (cell_byte[g+1]),
                .o_byte (cell_byte[g])
            );
        end
    endgenerate

    always_comb begin
        res_data = '0;
        if (ctrl.echo_valid) begin
            res_data[7:0] = i_s_axis_tdata;
        end
        if (ctrl.frame_done) begin
            for (int w = 0; w < crlfp_pkg::NUM_WORDS; w++) begin
                for (int b = 0; b < crlfp_pkg::WORD_BYTES; b++) begin
                    res_data[8 + w*crlfp_pkg::WORD_W + 8*b +: 8] =
                        cell_byte[w*crlfp_pkg::WORD_BYTES + b];
                end
            end
        end
        res_user = {ctrl.frame_done, ctrl.echo_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc;
                end
            end else if (in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else if (in_acc) begin
                r_out_data <= res_data;
                r_out_user <= res_user;
            end
        end else if (in_acc) begin
            r_skid_data <= res_data;
            r_skid_user <= res_user;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while output register is empty");

    a_done_is_echo_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[1]) |->
            (r_out_user[0] && (r_out_data[7:0] == crlfp_pkg::BYTE_CR)))
        else $error("frame done on an item that is not an echoed CR");

    a_no_words_without_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user[1]) |->
            (r_out_data[crlfp_pkg::OUT_DATA_W-1:8] == '0))
        else $error("payload words present without frame done");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_axis_tready))
        else $error("skid loaded while output register could take the item");
`endif

endmodule

// ----- design/crlfp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlfp_cell
// one payload byte cell; takes its neighbor's byte on every shift
// ----------------------------------------------------------------------------
module crlfp_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- design/crlfp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlfp_ctrl
// framing state machine: header hunt, payload count, trailer check
// ----------------------------------------------------------------------------
module crlfp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_overrun,
    output crlfp_pkg::t_ctrl    o_ctrl
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LF      = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TRL_LF  = 3'd3,
        PH_TRL_CR  = 3'd4
    } t_phase;

    localparam logic [crlfp_pkg::IDX_W-1:0] IDX_LAST =
        crlfp_pkg::IDX_W'(crlfp_pkg::PAYLOAD_BYTES - 1);

    t_phase                       r_phase;
    t_phase                       n_phase;
    logic [crlfp_pkg::IDX_W-1:0]  r_idx;
    logic [crlfp_pkg::IDX_W-1:0]  n_idx;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (i_overrun) begin
            n_phase = PH_HUNT;
            n_idx   = '0;
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    n_phase = (i_byte == crlfp_pkg::BYTE_CR) ? PH_LF : PH_HUNT;
                end
                PH_LF: begin
                    if (i_byte == crlfp_pkg::BYTE_LF) begin
                        n_idx   = '0;
                        n_phase = PH_PAYLOAD;
                    end else if (i_byte != crlfp_pkg::BYTE_CR) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_idx == IDX_LAST) begin
                        n_idx   = '0;
                        n_phase = PH_TRL_LF;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_TRL_LF: begin
                    n_phase = (i_byte == crlfp_pkg::BYTE_LF) ? PH_TRL_CR : PH_HUNT;
                end
                PH_TRL_CR: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        o_ctrl.echo_valid = !i_overrun;
        o_ctrl.store_en   = i_accept && !i_overrun && (r_phase == PH_PAYLOAD);
        o_ctrl.frame_done = !i_overrun && (r_phase == PH_TRL_CR)
                            && (i_byte == crlfp_pkg::BYTE_CR);
    end

endmodule

// ----- test/crlf_framed_pose_record_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_framed_pose_record_parser_core_tb
// self-checking bench for the cr-lf framed pose record parser
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes comes first: extreme byte values, two
// overruns, a repeated header cr and one good record. Random record traffic
// follows: mostly well-formed records with random payload, plus broken
// trailers, overruns at random points and loose noise bytes. Every output
// item is checked field by field against an in-bench parser model, under
// four sender/receiver idle mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module crlf_framed_pose_record_parser_core_tb;

    localparam int unsigned CLK_HALF    = 5;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 250;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned HOLD_AT     = 100;

    typedef enum logic [2:0] {
        HUNT_CR, WAIT_LF, PAYLOAD, WAIT_TRL_LF, WAIT_TRL_CR
    } t_parse_phase;

    typedef struct packed {
        logic                                                    echo_valid;
        logic [7:0]                                              echo_byte;
        logic                                                    frame_done;
        logic [crlfp_pkg::NUM_WORDS-1:0][crlfp_pkg::WORD_W-1:0]  words;
    } t_pose_result;

    typedef struct packed {
        logic [7:0] rx;
        logic       ovr;
        logic [4:0] reps;
        logic [7:0] step;
        logic       typed;
        logic       ev;
        logic [7:0] eb;
        logic       fd;
    } t_stim_row;

    localparam int unsigned NUM_ROWS = 9;
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'h00, 1'b0, 5'd1,  8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 5'd1,  8'h00, 1'b1, 1'b1, 8'hFF, 1'b0},
        '{8'hFF, 1'b1, 5'd1,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h0D, 1'b0, 5'd2,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h0A, 1'b0, 5'd1,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h00, 1'b0, 5'd24, 8'h0B, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h0A, 1'b0, 5'd1,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h0D, 1'b0, 5'd1,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h0D, 1'b1, 5'd1,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [7:0]                        i_s_axis_tdata;  // rx_byte
    logic [0:0]                        i_s_axis_tuser;  // overrun
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    // echo_byte, heading_word, roll_word, pitch_word, pos_x_word,
    // pos_y_word, yaw_rate_word
    logic [crlfp_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;
    // echo_valid, frame_done
    logic [crlfp_pkg::OUT_USER_W-1:0]  o_m_axis_tuser;

    t_parse_phase   parse_phase;
    logic [4:0]     payload_idx;
    logic [7:0]     payload_mem [crlfp_pkg::PAYLOAD_BYTES];
    t_pose_result   pending_results [$];

    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    bit             hold_done;
    int unsigned    hold_left;
    int unsigned    cycle_count;
    int unsigned    items_sent;
    int unsigned    results_checked;
    int unsigned    records_seen;
    int unsigned    input_stall_cycles;
    int unsigned    error_count;

    string word_names [crlfp_pkg::NUM_WORDS] = '{"heading_word", "roll_word",
                                                 "pitch_word", "pos_x_word",
                                                 "pos_y_word", "yaw_rate_word"};

    crlf_framed_pose_record_parser_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic t_pose_result parse_byte(input logic [7:0] rx, input logic ovr);
        t_pose_result r;
        r = '0;
        if (ovr) begin
            parse_phase = HUNT_CR;
            payload_idx = '0;
            return r;
        end
        r.echo_valid = 1'b1;
        r.echo_byte  = rx;
        case (parse_phase)
            HUNT_CR: begin
                parse_phase = (rx == crlfp_pkg::BYTE_CR) ? WAIT_LF : HUNT_CR;
            end
            WAIT_LF: begin
                if (rx == crlfp_pkg::BYTE_LF) begin
                    payload_idx = '0;
                    parse_phase = PAYLOAD;
                end else if (rx != crlfp_pkg::BYTE_CR) begin
                    parse_phase = HUNT_CR;
                end
            end
            PAYLOAD: begin
                if (payload_idx < crlfp_pkg::PAYLOAD_BYTES)
                    payload_mem[payload_idx] = rx;
                payload_idx = payload_idx + 5'd1;
                if (payload_idx >= crlfp_pkg::PAYLOAD_BYTES || payload_idx == 5'd0) begin
                    payload_idx = '0;
                    parse_phase = WAIT_TRL_LF;
                end
            end
            WAIT_TRL_LF: begin
                parse_phase = (rx == crlfp_pkg::BYTE_LF) ? WAIT_TRL_CR : HUNT_CR;
            end
            WAIT_TRL_CR: begin
                if (rx == crlfp_pkg::BYTE_CR) begin
                    r.frame_done = 1'b1;
                    for (int j = 0; j < crlfp_pkg::NUM_WORDS; j++)
                        for (int k = 0; k < crlfp_pkg::WORD_BYTES; k++)
                            r.words[j][8*k +: 8] =
                                payload_mem[crlfp_pkg::WORD_BYTES*j + k];
                end
                parse_phase = HUNT_CR;
            end
            default: begin
                parse_phase = HUNT_CR;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return crlfp_pkg::BYTE_CR;
            1: return crlfp_pkg::BYTE_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called right after a rising edge; returns at the edge that takes the item
    task automatic send_byte(input logic [7:0] rx, input logic ovr, input bit typed,
                             input t_pose_result typed_res);
        t_pose_result predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rx;
        i_s_axis_tuser  <= ovr;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = parse_byte(rx, ovr);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic send_random_sequence();
        logic [7:0] seq_b [32];
        logic       seq_o [32];
        int         kind;
        int         n;
        int         pos;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        n = 0;
        if (kind == 9) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                seq_b[i] = rand_byte();
                seq_o[i] = ($urandom_range(0, 7) == 0);
            end
        end else begin
            repeat ($urandom_range(1, 3)) begin
                seq_b[n] = crlfp_pkg::BYTE_CR;
                n++;
            end
            seq_b[n] = crlfp_pkg::BYTE_LF;
            n++;
            repeat (crlfp_pkg::PAYLOAD_BYTES) begin
                seq_b[n] = rand_byte();
                n++;
            end
            seq_b[n] = crlfp_pkg::BYTE_LF;
            seq_b[n+1] = crlfp_pkg::BYTE_CR;
            n += 2;
            for (int i = 0; i < n; i++)
                seq_o[i] = 1'b0;
            if (kind == 6) begin
                b = rand_byte();
                seq_b[n-2] = (b == crlfp_pkg::BYTE_LF) ? 8'h00 : b;
            end else if (kind == 7) begin
                b = rand_byte();
                seq_b[n-1] = (b == crlfp_pkg::BYTE_CR) ? 8'hFF : b;
            end else if (kind == 8) begin
                pos = $urandom_range(0, n - 1);
                seq_o[pos] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
            send_byte(seq_b[i], seq_o[i], 1'b0, '0);
    endtask

    task automatic check_result();
        t_pose_result want;
        t_pose_result got;
        got.echo_valid = o_m_axis_tuser[0];
        got.frame_done = o_m_axis_tuser[1];
        got.echo_byte  = o_m_axis_tdata[7:0];
        for (int j = 0; j < crlfp_pkg::NUM_WORDS; j++)
            got.words[j] = o_m_axis_tdata[8 + crlfp_pkg::WORD_W*j +: crlfp_pkg::WORD_W];
        results_checked++;
        if (got.frame_done)
            records_seen++;
        if (pending_results.size() == 0) begin
            $error("unexpected output item: tdata %h tuser %h",
                   o_m_axis_tdata, o_m_axis_tuser);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.echo_valid !== want.echo_valid) begin
            $error("echo_valid expected %0d got %0d", want.echo_valid, got.echo_valid);
            error_count++;
        end
        if (got.echo_byte !== want.echo_byte) begin
            $error("echo_byte expected %h got %h", want.echo_byte, got.echo_byte);
            error_count++;
        end
        if (got.frame_done !== want.frame_done) begin
            $error("frame_done expected %0d got %0d", want.frame_done, got.frame_done);
            error_count++;
        end
        for (int j = 0; j < crlfp_pkg::NUM_WORDS; j++) begin
            if (got.words[j] !== want.words[j]) begin
                $error("%s expected %h got %h", word_names[j], want.words[j],
                       got.words[j]);
                error_count++;
            end
        end
    endtask

    // output side: check taken items, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_result();
        if (!hold_done && items_sent >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_s_axis_tvalid && !o_s_axis_tready)
            input_stall_cycles++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_pose_result typed_res;
        t_stim_row    row;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        parse_phase     = HUNT_CR;
        payload_idx     = '0;
        for (int i = 0; i < crlfp_pkg::PAYLOAD_BYTES; i++)
            payload_mem[i] = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            typed_res = '0;
            typed_res.echo_valid = row.ev;
            typed_res.echo_byte  = row.eb;
            typed_res.frame_done = row.fd;
            for (int k = 0; k < row.reps; k++)
                send_byte(row.rx + 8'(k) * row.step, row.ovr, row.typed, typed_res);
        end

        // random records under four idle mixes
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            while (items_sent < NUM_ROWS + (p + 1) * PHASE_ITEMS)
                send_random_sequence();
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("summary: %0d input items, %0d output items checked, %0d records completed",
                 items_sent, results_checked, records_seen);
        $display("summary: %0d cycles with the input held back, %0d mismatches",
                 input_stall_cycles, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/crlfp_pkg.sv
design/crlfp_cell.sv
design/crlfp_ctrl.sv
design/crlf_framed_pose_record_parser_core.sv
test/crlf_framed_pose_record_parser_core_tb.sv
